/* hw/rtl/assert_macros.svh */
// Assertion macros for the checks in the top level of the frame checker.
// No dependencies; the checks drop out when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// condition a implies condition c in the same cycle
`define ASSERT_IMP(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
// condition a implies condition c in the next cycle
`define ASSERT_NXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define ASSERT_IMP(lbl, clk, rst_n, a, c)
`define ASSERT_NXT(lbl, clk, rst_n, a, c)
`endif
`endif

/* hw/rtl/mrfc_pkg.sv */
// Shared types, constants and the CRC-16 byte step for the reply frame checker.
// No dependencies.
package mrfc_pkg;

    localparam int FRAME_LEN  = 9;
    localparam int IDX_W      = 4;
    localparam int OUT_W      = 56;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;
    // ceil(2^19 / 10): exact divide by ten for any 16-bit value
    localparam logic [15:0] RECIP10  = 16'd52429;
    localparam int RECIP_SHIFT = 19;

    // one request as held in the queue between front and back
    typedef struct packed {
        logic       is_idle;
        logic [7:0] data;
    } rq_t;

    // queue status seen by the back end
    typedef struct packed {
        logic valid;
        rq_t  item;
    } rq_slot_t;

    // one Modbus CRC-16 byte: eight reflected shift steps
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int b = 0; b < 8; b++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

/* hw/rtl/mrfc_front.sv */
// Input side: accepts requests, tags them as byte or idle event, and queues them.
// Depends on mrfc_pkg.
module mrfc_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               in_mode,
    input  logic [7:0]         in_data,
    output mrfc_pkg::rq_slot_t head,
    input  logic               pop
);
    import mrfc_pkg::*;

    rq_t        entry_reg [0:1];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push;
    logic       do_pop;
    rq_t        new_item;

    // classify: mode high is a line-idle event, its data byte is dropped
    always_comb
    begin
        new_item.is_idle = in_mode;
        new_item.data    = in_mode ? 8'h00 : in_data;
    end

    assign in_ready   = (count_reg != 2'd2);
    assign push       = in_valid && in_ready;
    assign do_pop     = pop && (count_reg != 2'd0);
    assign head.valid = (count_reg != 2'd0);
    assign head.item  = entry_reg[rd_ptr_reg];

    // pointer and fill count
    always_comb
    begin
        wr_ptr_next = push   ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue entries
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= new_item;
    end

endmodule

/* hw/rtl/mrfc_back.sv */
// Back end: frame store, byte-serial CRC-16 check, divide by ten, result register.
// Depends on mrfc_pkg.
module mrfc_back (
    input  logic                      clk,
    input  logic                      rst_n,
    input  mrfc_pkg::rq_slot_t        head,
    output logic                      pop,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [mrfc_pkg::OUT_W-1:0] out_data
);
    import mrfc_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CRC  = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [7:0]       store_reg [0:FRAME_LEN-1];
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             ovr_reg, ovr_next;
    logic [IDX_W-1:0] snap_cnt_reg, snap_cnt_next;
    logic             snap_ovr_reg, snap_ovr_next;
    logic [15:0]      crc_reg, crc_next;
    logic [2:0]       step_reg, step_next;
    logic [31:0]      hprod_reg, tprod_reg;
    logic             hneg_reg;
    logic             ov_reg, ov_next;
    logic [OUT_W-1:0] od_reg;
    logic             store_we;
    logic             load_out;
    logic [15:0]      hraw, habs, traw;
    logic [12:0]      hq, hum, tq;
    logic             match;
    logic [OUT_W-1:0] result;

    assign hraw = {store_reg[3], store_reg[4]};
    assign traw = {store_reg[5], store_reg[6]};
    assign habs = hraw[15] ? (16'd0 - hraw) : hraw;

    // result fields from the registered products and the final CRC
    always_comb
    begin
        hq     = hprod_reg[RECIP_SHIFT +: 13];
        tq     = tprod_reg[RECIP_SHIFT +: 13];
        hum    = hneg_reg ? (13'd0 - hq) : hq;
        match  = (store_reg[7] == crc_reg[7:0]) && (store_reg[8] == crc_reg[15:8]);
        result = {snap_ovr_reg, snap_cnt_reg, tq, hum,
                  store_reg[2], store_reg[1], store_reg[0], match};
    end

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        ovr_next      = ovr_reg;
        snap_cnt_next = snap_cnt_reg;
        snap_ovr_next = snap_ovr_reg;
        crc_next      = crc_reg;
        step_next     = step_reg;
        pop           = 1'b0;
        store_we      = 1'b0;
        load_out      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (head.valid)
                begin
                    pop = 1'b1;
                    if (!head.item.is_idle)
                    begin
                        if (idx_reg < IDX_W'(FRAME_LEN))
                        begin
                            store_we = 1'b1;
                            idx_next = idx_reg + 1'b1;
                        end
                        else
                            ovr_next = 1'b1;
                    end
                    else
                    begin
                        snap_cnt_next = idx_reg;
                        snap_ovr_next = ovr_reg;
                        idx_next      = '0;
                        ovr_next      = 1'b0;
                        crc_next      = CRC_INIT;
                        step_next     = 3'd0;
                        state_next    = ST_CRC;
                    end
                end
            end
            ST_CRC:
            begin
                crc_next  = crc16_byte(crc_reg, store_reg[{1'b0, step_reg}]);
                step_next = step_reg + 3'd1;
                if (step_reg == 3'd6)
                    state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (!ov_reg || out_ready)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // output register: holds a result until taken
    always_comb
    begin
        ov_next = ov_reg;
        if (load_out)
            ov_next = 1'b1;
        else if (out_ready)
            ov_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            idx_reg      <= '0;
            ovr_reg      <= 1'b0;
            snap_cnt_reg <= '0;
            snap_ovr_reg <= 1'b0;
            ov_reg       <= 1'b0;
            for (int i = 0; i < FRAME_LEN; i++)
                store_reg[i] <= 8'h00;
        end
        else
        begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            ovr_reg      <= ovr_next;
            snap_cnt_reg <= snap_cnt_next;
            snap_ovr_reg <= snap_ovr_next;
            ov_reg       <= ov_next;
            if (store_we)
                store_reg[idx_reg] <= head.item.data;
        end
    end

    // datapath registers: CRC, reciprocal products, result
    always_ff @(posedge clk)
    begin
        crc_reg   <= crc_next;
        step_reg  <= step_next;
        hprod_reg <= habs * RECIP10;
        tprod_reg <= traw * RECIP10;
        hneg_reg  <= hraw[15];
        if (load_out)
            od_reg <= result;
    end

    assign out_valid = ov_reg;
    assign out_data  = od_reg;

endmodule

/* hw/rtl/modbus_reply_frame_checker.sv */
// Top level of the Modbus RTU reply frame checker.
// Depends on mrfc_pkg, mrfc_front, mrfc_back and assert_macros.svh.
//
// Slave channel s_axis: one request per received UART byte (tuser low,
// byte in tdata) or a line-idle event (tuser high) that closes the frame.
// Bytes fill a nine-entry frame store; bytes past the ninth are dropped
// and flagged as overrun. An idle event yields one result on m_axis:
// the CRC-16 match flag, header bytes, humidity and temperature divided
// by ten, the byte count and the overrun flag. Bytes yield no result.
// A two-entry queue parts the input from the checker, so requests are
// taken while a result waits on m_axis.
// Timing: a byte request is held in the queue and then written to the
// frame store; one can be accepted every cycle while the checker is idle.
// For an idle event the checker snapshots count and overrun and sets up
// the CRC, runs the byte-serial CRC over bytes 0..6, then loads the result
// into the output register. A stalled m_axis holds the result and then
// the queue fills, s_axis_tready falls. Reset clears store, count, overrun.
`include "assert_macros.svh"
module modbus_reply_frame_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  logic        s_axis_tuser,   // [0] mode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata    // [0] crc_match, [8:1] station_address,
                                        // [16:9] function_code, [24:17] payload_count,
                                        // [37:25] humidity, [50:38] temperature,
                                        // [54:51] bytes_received, [55] overrun
);
    import mrfc_pkg::*;

    rq_slot_t head;
    logic     pop;

    mrfc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_mode  (s_axis_tuser),
        .in_data  (s_axis_tdata),
        .head     (head),
        .pop      (pop)
    );

    mrfc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .pop       (pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

    // checks
    `ASSERT_IMP(a_pop_nonempty, clk, rst_n, pop, head.valid)
    `ASSERT_IMP(a_count_range, clk, rst_n, m_axis_tvalid, m_axis_tdata[54:51] <= 4'd9)
    `ASSERT_IMP(a_ovr_full, clk, rst_n, m_axis_tvalid && m_axis_tdata[55], m_axis_tdata[54:51] == 4'd9)
    `ASSERT_NXT(a_pop_frees, clk, rst_n, pop && !(s_axis_tvalid && s_axis_tready), s_axis_tready)

endmodule
